[hdl/sfkd_pkg.sv]
// shared constants, types and the knob word check for the knob frame deframer
// no dependencies
package sfkd_pkg;

    localparam int KNOB_COUNT = 7;
    localparam int OUT_KNOBS  = 7;
    localparam int WORDS_END  = 4 * KNOB_COUNT;
    localparam int POS_W      = $clog2(WORDS_END + 2);
    localparam int IDX_W      = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;

    localparam logic [7:0]  SYNC_A   = 8'hAA;
    localparam logic [7:0]  SYNC_B   = 8'h55;
    localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [OUT_KNOBS-1:0][31:0] t_knob_vec;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_GOT_A   = 3'b010,
        PH_COLLECT = 3'b100
    } t_phase;

    // negative zero, or a non-negative pattern no larger than 1.0
    function automatic logic word_ok(input logic [31:0] w);
        word_ok = (w == NEG_ZERO) || (!w[31] && (w <= ONE_BITS));
    endfunction

endpackage

[hdl/sync_framed_knob_deframer.sv]
// knob frame deframer: one byte beat in, at most one frame of seven knobs out
// the accepted closing byte passes the input register, then the result register, before its result beat shows
// throughput: one byte per cycle while the result side does not stall, set by the input register feeding the parser
// each byte is parsed in one pass between the input register and the result register
// reset (synchronous, active low): hunting for sync, no beats held; knob store not cleared
// depends on sfkd_pkg and sfkd_parser
module sync_framed_knob_deframer
    import sfkd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_knob_0,
    output logic [31:0] o_knob_1,
    output logic [31:0] o_knob_2,
    output logic [31:0] o_knob_3,
    output logic [31:0] o_knob_4,
    output logic [31:0] o_knob_5,
    output logic [31:0] o_knob_6,
    output logic        o_bypass_on
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_knob_vec  r_out_knobs;
    logic       r_out_bypass;

    logic       advance;
    logic       in_accept;
    logic       done;
    t_knob_vec  knobs;
    logic       bypass;

    // the byte in the input register moves on once the result register can take a beat
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    sfkd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_done   (done),
        .o_knobs  (knobs),
        .o_bypass (bypass)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && done) begin
            r_out_knobs  <= knobs;
            r_out_bypass <= bypass;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_knob_0    = r_out_knobs[0];
    assign o_knob_1    = r_out_knobs[1];
    assign o_knob_2    = r_out_knobs[2];
    assign o_knob_3    = r_out_knobs[3];
    assign o_knob_4    = r_out_knobs[4];
    assign o_knob_5    = r_out_knobs[5];
    assign o_knob_6    = r_out_knobs[6];
    assign o_bypass_on = r_out_bypass;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && done) |=> o_out_valid)
        else $error("completed frame not presented");

    a_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid && $stable(r_in_byte))
        else $error("held byte lost while blocked");

endmodule

[hdl/sfkd_parser.sv]
// frame parser: sync hunt, knob word assembly and check, knob store
// depends on sfkd_pkg
module sfkd_parser
    import sfkd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output logic       o_done,
    output t_knob_vec  o_knobs,
    output logic       o_bypass
);

    t_phase       r_phase, n_phase;
    t_pos         r_pos, n_pos;
    logic         r_frame_ok, n_frame_ok;
    logic         r_bypass, n_bypass;
    logic [23:0]  r_word_lo;
    logic [31:0]  r_store [KNOB_COUNT];

    logic [31:0]  word;
    t_idx         widx;
    logic         in_words;
    logic         word_end;

    assign in_words = (r_pos < t_pos'(WORDS_END));
    assign word_end = in_words && (r_pos[1:0] == 2'd3);
    assign word     = {i_byte, r_word_lo};
    assign widx     = t_idx'(r_pos >> 2);

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_frame_ok = r_frame_ok;
        n_bypass   = r_bypass;
        o_done     = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_COLLECT: begin
                    if (in_words) begin
                        if (word_end && !word_ok(word)) begin
                            n_frame_ok = 1'b0;
                        end
                        n_pos = r_pos + t_pos'(1);
                    end else if (r_pos == t_pos'(WORDS_END)) begin
                        n_bypass = (i_byte != 8'd0);
                        n_pos    = r_pos + t_pos'(1);
                    end else begin
                        // second switch byte closes the frame
                        o_done     = r_frame_ok;
                        n_frame_ok = 1'b1;
                        n_phase    = PH_HUNT;
                        n_pos      = '0;
                    end
                end
                PH_GOT_A: begin
                    if (i_byte == SYNC_B) begin
                        n_phase    = PH_COLLECT;
                        n_frame_ok = 1'b1;
                        n_bypass   = 1'b0;
                    end else begin
                        n_phase = (i_byte == SYNC_A) ? PH_GOT_A : PH_HUNT;
                    end
                    n_pos = '0;
                end
                default: begin
                    n_phase = (i_byte == SYNC_A) ? PH_GOT_A : PH_HUNT;
                    n_pos   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_pos      <= '0;
            r_frame_ok <= 1'b1;
            r_bypass   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_frame_ok <= n_frame_ok;
            r_bypass   <= n_bypass;
        end
    end

    // low three bytes gather here, the full word lands in the store on its top byte
    always_ff @(posedge i_clk) begin
        if (i_step && (r_phase == PH_COLLECT) && in_words) begin
            case (r_pos[1:0])
                2'd0: r_word_lo[7:0]   <= i_byte;
                2'd1: r_word_lo[15:8]  <= i_byte;
                2'd2: r_word_lo[23:16] <= i_byte;
                default: r_store[widx] <= word;
            endcase
        end
    end

    for (genvar j = 0; j < OUT_KNOBS; j++) begin : g_out
        if (j < KNOB_COUNT) begin : g_used
            assign o_knobs[j] = r_store[j];
        end else begin : g_zero
            assign o_knobs[j] = 32'd0;
        end
    end

    assign o_bypass = r_bypass;

    a_done_in_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_phase == PH_COLLECT) && (r_pos == t_pos'(WORDS_END + 1)))
        else $error("frame done outside the final switch byte");

    a_pos_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_COLLECT) |-> (r_pos == '0))
        else $error("byte position moved while hunting");

    a_sync_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (r_phase == PH_GOT_A) && (i_byte == SYNC_B))
            |=> (r_phase == PH_COLLECT) && (r_pos == '0) && r_frame_ok)
        else $error("sync pair did not start a frame");

endmodule

[tb/sv/sfkd_frame_checker.sv]
`timescale 1ns / 100ps
// frame checker for the knob frame deframer: follows the accepted byte beats, predicts
// the frames they complete and compares every result beat; depends on sfkd_pkg
module sfkd_frame_checker
    import sfkd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_knob_vec  i_knobs,
    input  logic       i_bypass_on,
    output int         o_pending,
    output int         o_fail_count
);

    typedef struct packed {
        t_knob_vec knobs;
        logic      bypass;
    } t_knob_frame;

    t_knob_frame frames_q[$];

    t_phase      phase;
    t_pos        pos;
    logic [31:0] words [KNOB_COUNT];
    logic        frame_ok;
    logic        bypass;

    // sign-clear patterns up to 1.0, plus negative zero
    function automatic logic knob_in_range(input logic [31:0] w);
        return (w == NEG_ZERO) || (w <= ONE_BITS);
    endfunction

    task automatic take_byte(input logic [7:0] b);
        t_knob_frame fr;
        if (phase == PH_COLLECT) begin
            if (pos < WORDS_END) begin
                words[pos / 4][8 * (pos % 4) +: 8] = b;
                if ((pos % 4) == 3 && !knob_in_range(words[pos / 4]))
                    frame_ok = 1'b0;
                pos = pos + 1'b1;
            end else if (pos == WORDS_END) begin
                bypass = (b != 8'd0);
                pos = pos + 1'b1;
            end else begin
                // closing switch byte, value ignored
                phase = PH_HUNT;
                pos = '0;
                if (frame_ok) begin
                    for (int k = 0; k < OUT_KNOBS; k++)
                        fr.knobs[k] = (k < KNOB_COUNT) ? words[k] : 32'd0;
                    fr.bypass = bypass;
                    frames_q.push_back(fr);
                end
                frame_ok = 1'b1;
            end
        end else if (phase == PH_GOT_A && b == SYNC_B) begin
            phase = PH_COLLECT;
            pos = '0;
            frame_ok = 1'b1;
            bypass = 1'b0;
        end else begin
            // a non-matching byte after the first sync byte is retried as a first sync byte
            phase = (b == SYNC_A) ? PH_GOT_A : PH_HUNT;
            pos = '0;
        end
    endtask

    task automatic check_beat();
        t_knob_frame want;
        if (frames_q.size() == 0) begin
            $display("%0t: result beat with no frame pending, knob_0 %h bypass %b",
                     $time, i_knobs[0], i_bypass_on);
            o_fail_count++;
        end else begin
            want = frames_q.pop_front();
            for (int k = 0; k < OUT_KNOBS; k++) begin
                if (i_knobs[k] !== want.knobs[k]) begin
                    $display("%0t: knob_%0d expected %h actual %h",
                             $time, k, want.knobs[k], i_knobs[k]);
                    o_fail_count++;
                end
            end
            if (i_bypass_on !== want.bypass) begin
                $display("%0t: bypass_on expected %b actual %b",
                         $time, want.bypass, i_bypass_on);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_HUNT;
            pos = '0;
            frame_ok = 1'b1;
            bypass = 1'b0;
            frames_q.delete();
            o_fail_count = 0;
        end else begin
            // results trail their closing byte, so compare before predicting
            if (i_out_valid && !i_out_stall)
                check_beat();
            if (i_in_valid && !i_in_stall)
                take_byte(i_rx_byte);
        end
        o_pending = frames_q.size();
    end

endmodule

[tb/sv/tb_sync_framed_knob_deframer.sv]
`timescale 1ns / 100ps
// testbench top for the knob frame deframer: byte stimulus, output stall, watchdog, verdict
// depends on sfkd_pkg, sync_framed_knob_deframer and sfkd_frame_checker
module tb_sync_framed_knob_deframer;
    import sfkd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 600;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte  = 8'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_knob_0, o_knob_1, o_knob_2, o_knob_3, o_knob_4, o_knob_5, o_knob_6;
    logic        o_bypass_on;

    int pending;
    int fail_count;
    int sent_bytes  = 0;
    int idle_cycles = 0;
    bit steady      = 1'b0;

    sync_framed_knob_deframer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_knob_0    (o_knob_0),
        .o_knob_1    (o_knob_1),
        .o_knob_2    (o_knob_2),
        .o_knob_3    (o_knob_3),
        .o_knob_4    (o_knob_4),
        .o_knob_5    (o_knob_5),
        .o_knob_6    (o_knob_6),
        .o_bypass_on (o_bypass_on)
    );

    sfkd_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_knobs      ({o_knob_6, o_knob_5, o_knob_4, o_knob_3, o_knob_2, o_knob_1, o_knob_0}),
        .i_bypass_on  (o_bypass_on),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat moved for %0d cycles", $time, idle_cycles);
            $display("tb_sync_framed_knob_deframer failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sent_bytes++;
    endtask

    task automatic send_frame(input t_knob_vec knobs, input logic [7:0] sw0,
                              input logic [7:0] sw1, input bit double_a);
        if (double_a)
            send_byte(SYNC_A);
        send_byte(SYNC_A);
        send_byte(SYNC_B);
        for (int k = 0; k < KNOB_COUNT; k++)
            for (int lane = 0; lane < 4; lane++)
                send_byte(knobs[k][8 * lane +: 8]);
        send_byte(sw0);
        send_byte(sw1);
    endtask

    function automatic logic [31:0] draw_knob(input bit bad);
        if (bad) begin
            case ($urandom_range(0, 3))
                0:       return ONE_BITS + 32'd1;
                1:       return 32'h7FC0_0000;
                2:       return ONE_BITS + 32'd1 + $urandom_range(0, 32'h4000_0000);
                default: return NEG_ZERO + $urandom_range(1, 32'h7FFF_FFFF);
            endcase
        end
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return ONE_BITS;
            2:       return NEG_ZERO;
            default: return $urandom_range(0, ONE_BITS);
        endcase
    endfunction

    // result side: short random stalls, one long hold-off to back the block up
    initial begin
        int n;
        int beats;
        beats = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            n = steady ? 0 : $urandom_range(0, 3);
            if (beats == 10)
                n = LONG_HOLD;
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            beats++;
        end
    end

    initial begin
        t_knob_vec  knobs;
        logic [7:0] b;
        bit         bad;
        bit         spoiled;
        int         good_frames;
        good_frames = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, knob range edges, sync corner cases
        send_byte(8'h00);
        send_byte(8'hFF);
        knobs = '0;
        send_frame(knobs, 8'h00, 8'h00, 1'b0);
        knobs[0] = ONE_BITS;
        knobs[1] = NEG_ZERO;
        knobs[2] = 32'h0000_0001;
        knobs[3] = 32'h3F7F_FFFF;
        knobs[4] = 32'h0000_0000;
        knobs[5] = ONE_BITS;
        knobs[6] = NEG_ZERO;
        send_frame(knobs, 8'hFF, 8'hFF, 1'b1);
        knobs[3] = ONE_BITS + 32'd1;
        send_frame(knobs, 8'h01, 8'h00, 1'b0);
        knobs[3] = 32'h3F7F_FFFF;
        knobs[6] = NEG_ZERO + 32'd1;
        send_frame(knobs, 8'h01, 8'h00, 1'b0);
        knobs[6] = NEG_ZERO;
        knobs[0] = 32'hFFFF_FFFF;
        send_frame(knobs, 8'h00, 8'h00, 1'b0);
        knobs[0] = 32'h7FC0_0000;
        send_frame(knobs, 8'h00, 8'h00, 1'b0);
        knobs[0] = 32'h7F80_0000;
        send_frame(knobs, 8'h00, 8'h00, 1'b0);
        knobs[0] = ONE_BITS;
        // lone first sync byte, then sync bytes carried as payload
        send_byte(SYNC_A);
        send_byte(8'h00);
        knobs[1] = 32'h3F55_AA55;
        knobs[2] = 32'h0055_AA00;
        send_frame(knobs, 8'h01, SYNC_A, 1'b0);
        send_frame(knobs, 8'h80, SYNC_B, 1'b0);

        // random: mostly well-formed frames, with noise, broken syncs and cut frames
        do begin
            if ($urandom_range(0, 5) == 0)
                steady = !steady;
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom_range(0, 255)));
            case ($urandom_range(0, 9))
                0: begin
                    b = 8'($urandom_range(0, 255));
                    if (b == SYNC_B)
                        b = 8'h00;
                    send_byte(SYNC_A);
                    send_byte(b);
                end
                1: begin
                    send_byte(SYNC_A);
                    send_byte(SYNC_B);
                    repeat ($urandom_range(1, 30))
                        send_byte(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
            spoiled = 1'b0;
            for (int k = 0; k < KNOB_COUNT; k++) begin
                bad = ($urandom_range(0, 29) == 0);
                knobs[k] = draw_knob(bad);
                spoiled |= bad;
            end
            b = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
            send_frame(knobs, b, 8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            if (!spoiled)
                good_frames++;
        end while (sent_bytes < 1900 || good_frames < 40);

        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_sync_framed_knob_deframer passed");
        else
            $display("tb_sync_framed_knob_deframer failed");
        $finish;
    end

endmodule
